// File: rtl/rldf_pkg.sv
`timescale 1ns / 1ps

package rldf_pkg;

   // field widths
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CELL_W      = 31;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned ERR_W       = 4;

   // register port
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CELL_W-1:0] CELL_COUNT_RESET = CELL_W'(1);

   // register index, taken from the word address bits
   typedef enum logic {
      REG_CELL_COUNT = 1'b0
   } reg_index_type;

   // stream constants
   localparam logic [BYTE_W-1:0] ESC_MARK     = 8'hFF;
   localparam logic [WORD_W-1:0] TIME_REC_LEN = 32'd4;
   localparam logic [WORD_W-1:0] SIZE_REC_LEN = 32'd8;

   typedef enum logic [KIND_W-1:0] {
      KIND_RUN   = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_TIME_LEN    = 4'd0,
      ERR_TIME_END    = 4'd1,
      ERR_SIZE_LEN    = 4'd2,
      ERR_SIZE_END    = 4'd3,
      ERR_CELLS       = 4'd4,
      ERR_NEGATIVE    = 4'd5,
      ERR_PAYLOAD_LEN = 4'd6,
      ERR_MALFORMED   = 4'd7,
      ERR_OVERFLOW    = 4'd8,
      ERR_PAYLOAD_END = 4'd9,
      ERR_COUNT       = 4'd10
   } err_type;

endpackage

// File: rtl/rldf_req_if.sv
`timescale 1ns / 1ps

interface rldf_req_if import rldf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/rldf_rsp_if.sv
`timescale 1ns / 1ps

interface rldf_rsp_if import rldf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [BYTE_W-1:0] run_value;
   logic [BYTE_W-1:0] run_length;
   logic [CELL_W-1:0] run_start;
   logic [WORD_W-1:0] frame_time_bits;
   logic [CELL_W-1:0] payload_bytes;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, output result_kind, output run_value, output run_length,
                   output run_start, output frame_time_bits, output payload_bytes,
                   output error_code, input ready);
   modport sink   (input valid, input result_kind, input run_value, input run_length,
                   input run_start, input frame_time_bits, input payload_bytes,
                   input error_code, output ready);
endinterface

// File: rtl/record_framed_rle_frame_decoder.sv
`timescale 1ns / 1ps
// Frame stream decoder: record lengths checked, payload run-length decoded.
// An accepted byte's result word is registered and appears on rsp_chan in the next cycle.
// Throughput: one byte per cycle; the single result register is refilled
// in the cycle it is taken, so req stalls only while a result waits unread.
// Reset (synchronous, active high) returns to the time record length, clears
// all counters and the error latch, and sets cell_count to 1.

module record_framed_rle_frame_decoder import rldf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rldf_req_if.sink              req_chan,
   rldf_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Where we are in the frame
   typedef enum logic [3:0] {
      PH_TLEN = 4'd0,   // leading time length
      PH_TIME = 4'd1,
      PH_TEND = 4'd2,   // trailing time length
      PH_SLEN = 4'd3,   // leading size length
      PH_NIN  = 4'd4,   // cell count word
      PH_NOUT = 4'd5,   // payload size word
      PH_SEND = 4'd6,   // trailing size length
      PH_PLEN = 4'd7,   // leading payload length
      PH_PAY  = 4'd8,   // payload bytes
      PH_PEND = 4'd9    // trailing payload length
   } phase_type;

   // Escape sequence progress inside the payload
   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_VALUE = 2'd1,
      ESC_COUNT = 2'd2
   } esc_type;

   logic [CELL_W-1:0] cell_count;

   rldf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cell_count (cell_count)
   );

   // Decoder state
   phase_type         phase_ff,        phase_in;
   logic [1:0]        byte_idx_ff,     byte_idx_in;
   logic [WORD_W-1:0] word_ff,         word_in;
   logic [WORD_W-1:0] held_time_ff,    held_time_in;
   logic [WORD_W-1:0] pay_size_ff,     pay_size_in;
   logic [WORD_W-1:0] pay_left_ff,     pay_left_in;
   logic [CELL_W-1:0] cells_ff,        cells_in;
   esc_type           esc_ff,          esc_in;
   logic [BYTE_W-1:0] esc_value_ff,    esc_value_in;
   logic              err_latched_ff,  err_latched_in;

   // Result register
   logic              rsp_valid_ff,    rsp_valid_in;
   kind_type          kind_ff,         kind_in;
   logic [BYTE_W-1:0] run_value_ff,    run_value_in;
   logic [BYTE_W-1:0] run_length_ff,   run_length_in;
   logic [CELL_W-1:0] run_start_ff,    run_start_in;
   logic [WORD_W-1:0] time_bits_ff,    time_bits_in;
   logic [CELL_W-1:0] pay_bytes_ff,    pay_bytes_in;
   err_type           err_code_ff,     err_code_in;

   logic              accept;
   logic              emit;            // accepted byte yields a result word
   logic [BYTE_W-1:0] data_b;
   logic [WORD_W-1:0] full_word;       // word completed by this byte
   logic              run_req;
   logic [BYTE_W-1:0] run_val;
   logic [BYTE_W-1:0] run_len;
   logic [WORD_W-1:0] run_end;
   logic              run_ovf;
   logic [WORD_W-1:0] cell_count_w;

   // Result register frees up when taken, so a new byte can enter same cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign data_b         = req_chan.data_byte;
   assign full_word      = {data_b, word_ff[WORD_W-BYTE_W-1:0]};
   assign cell_count_w   = WORD_W'(cell_count);

   // Run bounds check: start + len against the configured cell count
   assign run_end = WORD_W'(cells_ff) + WORD_W'(run_len);
   assign run_ovf = run_end > cell_count_w;

   always_comb begin
      phase_in       = phase_ff;
      byte_idx_in    = byte_idx_ff;
      word_in        = word_ff;
      held_time_in   = held_time_ff;
      pay_size_in    = pay_size_ff;
      pay_left_in    = pay_left_ff;
      cells_in       = cells_ff;
      esc_in         = esc_ff;
      esc_value_in   = esc_value_ff;
      err_latched_in = err_latched_ff;

      emit          = 1'b0;
      kind_in       = KIND_RUN;
      run_value_in  = '0;
      run_length_in = '0;
      run_start_in  = '0;
      time_bits_in  = '0;
      pay_bytes_in  = '0;
      err_code_in   = ERR_TIME_LEN;

      run_req = 1'b0;
      run_val = data_b;
      run_len = BYTE_W'(1);

      if (accept && !err_latched_ff) begin
         if (phase_ff == PH_PAY) begin
            pay_left_in = pay_left_ff - WORD_W'(1);
            unique case (esc_ff)
               ESC_NONE: begin
                  if (data_b == ESC_MARK) begin
                     esc_in = ESC_VALUE;
                  end else begin
                     run_req = 1'b1;
                  end
               end
               ESC_VALUE: begin
                  esc_value_in = data_b;
                  esc_in       = ESC_COUNT;
               end
               default: begin
                  esc_in  = ESC_NONE;
                  run_req = 1'b1;
                  run_val = esc_value_ff;
                  run_len = data_b;
               end
            endcase

            priority if (run_req && run_ovf) begin
               emit           = 1'b1;
               err_latched_in = 1'b1;
               kind_in        = KIND_ERROR;
               err_code_in    = ERR_OVERFLOW;
            end else begin
               // zero-length run passes the check but emits nothing
               if (run_req && (run_len != '0)) begin
                  emit          = 1'b1;
                  kind_in       = KIND_RUN;
                  run_value_in  = run_val;
                  run_length_in = run_len;
                  run_start_in  = cells_ff;
                  cells_in      = run_end[CELL_W-1:0];
               end
               if (pay_left_in == '0) begin
                  if (esc_in != ESC_NONE) begin
                     // payload ended inside an escape
                     emit           = 1'b1;
                     err_latched_in = 1'b1;
                     kind_in        = KIND_ERROR;
                     err_code_in    = ERR_MALFORMED;
                  end else begin
                     phase_in = PH_PEND;
                  end
               end
            end
         end else begin
            // little-endian length/data word assembly
            if (byte_idx_ff == 2'd3) begin
               word_in     = '0;
               byte_idx_in = 2'd0;
            end else begin
               word_in[{byte_idx_ff, 3'b000} +: BYTE_W] = data_b;
               byte_idx_in = byte_idx_ff + 2'd1;
            end

            if (byte_idx_ff == 2'd3) begin
               unique case (phase_ff)
                  PH_TLEN: begin
                     if (full_word != TIME_REC_LEN) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_TIME_LEN;
                     end else begin
                        phase_in = PH_TIME;
                     end
                  end
                  PH_TIME: begin
                     held_time_in = full_word;
                     phase_in     = PH_TEND;
                  end
                  PH_TEND: begin
                     if (full_word != TIME_REC_LEN) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_TIME_END;
                     end else begin
                        phase_in = PH_SLEN;
                     end
                  end
                  PH_SLEN: begin
                     if (full_word != SIZE_REC_LEN) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_SIZE_LEN;
                     end else begin
                        phase_in = PH_NIN;
                     end
                  end
                  PH_NIN: begin
                     // cell count word parks in pay_left until checked
                     pay_left_in = full_word;
                     phase_in    = PH_NOUT;
                  end
                  PH_NOUT: begin
                     pay_size_in = full_word;
                     phase_in    = PH_SEND;
                  end
                  PH_SEND: begin
                     priority if (full_word != SIZE_REC_LEN) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_SIZE_END;
                     end else if (pay_left_ff != cell_count_w) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_CELLS;
                     end else if (pay_size_ff[WORD_W-1]) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_NEGATIVE;
                     end else begin
                        phase_in = PH_PLEN;
                     end
                  end
                  PH_PLEN: begin
                     if (full_word != pay_size_ff) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_PAYLOAD_LEN;
                     end else begin
                        pay_left_in = pay_size_ff;
                        cells_in    = '0;
                        esc_in      = ESC_NONE;
                        phase_in    = (pay_size_ff == '0) ? PH_PEND : PH_PAY;
                     end
                  end
                  PH_PEND: begin
                     priority if (full_word != pay_size_ff) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_PAYLOAD_END;
                     end else if (WORD_W'(cells_ff) != cell_count_w) begin
                        emit = 1'b1; err_latched_in = 1'b1;
                        kind_in = KIND_ERROR; err_code_in = ERR_COUNT;
                     end else begin
                        emit         = 1'b1;
                        kind_in      = KIND_FRAME;
                        time_bits_in = held_time_ff;
                        pay_bytes_in = pay_size_ff[CELL_W-1:0];
                        phase_in     = PH_TLEN;
                     end
                  end
                  default: begin
                     phase_in = PH_TLEN;
                  end
               endcase
            end
         end
      end

      // Result register: load on a new result, drop when taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TLEN;
         byte_idx_ff    <= '0;
         word_ff        <= '0;
         held_time_ff   <= '0;
         pay_size_ff    <= '0;
         pay_left_ff    <= '0;
         cells_ff       <= '0;
         esc_ff         <= ESC_NONE;
         esc_value_ff   <= '0;
         err_latched_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_idx_ff    <= byte_idx_in;
         word_ff        <= word_in;
         held_time_ff   <= held_time_in;
         pay_size_ff    <= pay_size_in;
         pay_left_ff    <= pay_left_in;
         cells_ff       <= cells_in;
         esc_ff         <= esc_in;
         esc_value_ff   <= esc_value_in;
         err_latched_ff <= err_latched_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff       <= kind_in;
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         run_start_ff  <= run_start_in;
         time_bits_ff  <= time_bits_in;
         pay_bytes_ff  <= pay_bytes_in;
         err_code_ff   <= err_code_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_kind     = kind_ff;
   assign rsp_chan.run_value       = run_value_ff;
   assign rsp_chan.run_length      = run_length_ff;
   assign rsp_chan.run_start       = run_start_ff;
   assign rsp_chan.frame_time_bits = time_bits_ff;
   assign rsp_chan.payload_bytes   = pay_bytes_ff;
   assign rsp_chan.error_code      = (kind_ff == KIND_ERROR) ? err_code_ff : ERR_TIME_LEN;

   // Once latched, the decoder never produces another word
   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      err_latched_ff |-> !emit)
      else $error("result produced after error latch");

   // A shown run always covers at least one cell
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == KIND_RUN)) |-> (run_length_ff != '0))
      else $error("zero-length run shown");

   // Escape progress exists only inside the payload
   a_esc_in_payload: assert property (@(posedge clock) disable iff (reset)
      (esc_ff != ESC_NONE) |-> (phase_ff == PH_PAY))
      else $error("escape state outside payload");

   // An error word sets the latch for the following cycle
   a_err_latches: assert property (@(posedge clock) disable iff (reset)
      (emit && (kind_in == KIND_ERROR)) |=> err_latched_ff)
      else $error("error word without latch");

endmodule

// File: rtl/rldf_csr.sv
`timescale 1ns / 1ps

module rldf_csr import rldf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CELL_W-1:0]     cell_count
);

   logic [CELL_W-1:0] cell_count_ff;
   logic [CELL_W-1:0] cell_count_in;
   reg_index_type     reg_index;
   logic              wr_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cell_count_in = cell_count_ff;
      if (wr_en && (reg_index == REG_CELL_COUNT)) begin
         cell_count_in = pwdata[CELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= CELL_COUNT_RESET;
      end else begin
         cell_count_ff <= cell_count_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_CELL_COUNT: prdata = CSR_DATA_W'(cell_count_ff);
         default:        prdata = '0;
      endcase
   end

   assign cell_count = cell_count_ff;

endmodule

// File: bench/record_framed_rle_frame_decoder_tb.sv
`timescale 1ns / 1ps

module record_framed_rle_frame_decoder_tb;
   import rldf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   // the random frames stop once this many bytes have gone in overall
   localparam int unsigned RANDOM_STOP = 560;
   localparam int          NO_SPOIL    = -1;
   localparam logic [CSR_ADDR_W-1:0] CELL_COUNT_ADDR = CSR_ADDR_W'(4 * REG_CELL_COUNT);

   // where the frame parser stands between bytes
   typedef enum logic [3:0] {
      ST_TIME_LEN, ST_TIME, ST_TIME_END, ST_SIZE_LEN, ST_CELLS,
      ST_PAYLOAD_SIZE, ST_SIZE_END, ST_PAYLOAD_LEN, ST_PAYLOAD, ST_PAYLOAD_END
   } stage_type;

   typedef enum logic [1:0] {
      ESC_NONE, ESC_VALUE, ESC_COUNT
   } esc_state_type;

   // receiver ready patterns
   typedef enum logic [1:0] {
      RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY
   } rx_mode_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] length;
      logic [CELL_W-1:0] start;
      logic [WORD_W-1:0] time_bits;
      logic [CELL_W-1:0] payload;
      err_type           code;
   } decoded_word_type;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rldf_req_if req_chan ();
   rldf_rsp_if rsp_chan ();

   record_framed_rle_frame_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ---------------------------------------------------------------
   // Decoder state as this bench tracks it, plus the expected words
   // ---------------------------------------------------------------
   logic [CELL_W-1:0] cell_count_mirror = CELL_COUNT_RESET;
   stage_type         stage             = ST_TIME_LEN;
   logic [1:0]        word_byte_idx     = '0;
   logic [WORD_W-1:0] word_acc          = '0;
   logic [WORD_W-1:0] time_word         = '0;
   logic [WORD_W-1:0] size_word         = '0;
   // holds the cell count word until the size record closes, then
   // counts payload bytes still to come
   logic [WORD_W-1:0] bytes_left        = '0;
   logic [CELL_W-1:0] cells_done        = '0;
   esc_state_type     esc_state         = ESC_NONE;
   logic [BYTE_W-1:0] esc_byte          = '0;
   bit                latched           = 1'b0;

   decoded_word_type  decoded_q[$];

   int unsigned       cycle_count = 0;
   int unsigned       mismatches  = 0;
   int unsigned       sent_bytes  = 0;
   int unsigned       burst_left  = 0;
   int unsigned       hold_cycles = 0;
   rx_mode_type       stall_mode  = RX_ALWAYS;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a word never shows up
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // First error wins; every later byte is dropped silently.
   function automatic void flag_error(err_type code);
      decoded_word_type d;
      d = '0;
      d.kind = KIND_ERROR;
      d.code = code;
      latched = 1'b1;
      decoded_q = {decoded_q, d};
   endfunction

   // Overflow is checked even for an empty run; empty runs emit nothing.
   function automatic void add_run(logic [BYTE_W-1:0] value, logic [BYTE_W-1:0] len);
      decoded_word_type d;
      if ({1'b0, cells_done} + WORD_W'(len) > {1'b0, cell_count_mirror}) begin
         flag_error(ERR_OVERFLOW);
         return;
      end
      if (len == 0)
         return;
      d = '0;
      d.kind   = KIND_RUN;
      d.value  = value;
      d.length = len;
      d.start  = cells_done;
      decoded_q = {decoded_q, d};
      cells_done = cells_done + CELL_W'(len);
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] w;
      decoded_word_type  d;
      if (latched)
         return;

      if (stage == ST_PAYLOAD) begin
         bytes_left = bytes_left - 1;
         case (esc_state)
            ESC_NONE: begin
               if (b == ESC_MARK)
                  esc_state = ESC_VALUE;
               else
                  add_run(b, 8'd1);
            end
            ESC_VALUE: begin
               esc_byte  = b;
               esc_state = ESC_COUNT;
            end
            default: begin
               esc_state = ESC_NONE;
               add_run(esc_byte, b);
            end
         endcase
         // payload ran out: malformed if in the middle of an escape, else on to the trailing length
         if (!latched && bytes_left == 0) begin
            if (esc_state != ESC_NONE)
               flag_error(ERR_MALFORMED);
            else
               stage = ST_PAYLOAD_END;
         end
         return;
      end

      // length and header words arrive little-endian
      word_acc = word_acc | (WORD_W'(b) << (8 * word_byte_idx));
      if (word_byte_idx != 2'd3) begin
         word_byte_idx = word_byte_idx + 2'd1;
         return;
      end
      w             = word_acc;
      word_acc      = '0;
      word_byte_idx = '0;

      case (stage)
         ST_TIME_LEN: begin
            if (w != TIME_REC_LEN) flag_error(ERR_TIME_LEN);
            else stage = ST_TIME;
         end
         ST_TIME: begin
            time_word = w;
            stage     = ST_TIME_END;
         end
         ST_TIME_END: begin
            if (w != TIME_REC_LEN) flag_error(ERR_TIME_END);
            else stage = ST_SIZE_LEN;
         end
         ST_SIZE_LEN: begin
            if (w != SIZE_REC_LEN) flag_error(ERR_SIZE_LEN);
            else stage = ST_CELLS;
         end
         ST_CELLS: begin
            bytes_left = w;
            stage      = ST_PAYLOAD_SIZE;
         end
         ST_PAYLOAD_SIZE: begin
            size_word = w;
            stage     = ST_SIZE_END;
         end
         ST_SIZE_END: begin
            if (w != SIZE_REC_LEN) flag_error(ERR_SIZE_END);
            else if (bytes_left != {1'b0, cell_count_mirror}) flag_error(ERR_CELLS);
            else if (size_word[WORD_W-1]) flag_error(ERR_NEGATIVE);
            else stage = ST_PAYLOAD_LEN;
         end
         ST_PAYLOAD_LEN: begin
            if (w != size_word) begin
               flag_error(ERR_PAYLOAD_LEN);
            end else begin
               bytes_left = size_word;
               cells_done = '0;
               esc_state  = ESC_NONE;
               stage      = (size_word == 0) ? ST_PAYLOAD_END : ST_PAYLOAD;
            end
         end
         ST_PAYLOAD_END: begin
            if (w != size_word) begin
               flag_error(ERR_PAYLOAD_END);
            end else if (cells_done != cell_count_mirror) begin
               flag_error(ERR_COUNT);
            end else begin
               d = '0;
               d.kind      = KIND_FRAME;
               d.time_bits = time_word;
               d.payload   = size_word[CELL_W-1:0];
               decoded_q = {decoded_q, d};
               stage = ST_TIME_LEN;
            end
         end
         default: stage = ST_TIME_LEN;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Result side: ready pattern and the word checker
   // ---------------------------------------------------------------

   // A requested hold is counted down here; otherwise follow the pattern.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_ALWAYS:       rsp_chan.ready <= 1'b1;
            RX_COIN:         rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_FOURTH: rsp_chan.ready <= (cycle_count % 4 == 0);
            default:         rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic bit field_ok(string name, logic [WORD_W-1:0] want,
                                   logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      decoded_word_type want;
      bit               ok;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (decoded_q.size() == 0) begin
            $error("result word with nothing expected, kind 0x%0h", rsp_chan.result_kind);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            ok = 1'b1;
            ok &= field_ok("result_kind", WORD_W'(want.kind), WORD_W'(rsp_chan.result_kind));
            ok &= field_ok("run_value", WORD_W'(want.value), WORD_W'(rsp_chan.run_value));
            ok &= field_ok("run_length", WORD_W'(want.length), WORD_W'(rsp_chan.run_length));
            ok &= field_ok("run_start", WORD_W'(want.start), WORD_W'(rsp_chan.run_start));
            ok &= field_ok("frame_time_bits", want.time_bits, rsp_chan.frame_time_bits);
            ok &= field_ok("payload_bytes", WORD_W'(want.payload),
                           WORD_W'(rsp_chan.payload_bytes));
            ok &= field_ok("error_code", WORD_W'(want.code), WORD_W'(rsp_chan.error_code));
            if (!ok)
               mismatches++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Byte side
   // ---------------------------------------------------------------

   // Offers one byte and returns at the edge that takes it. Bytes go out
   // in bursts; between bursts valid may drop.
   task automatic send_byte(logic [BYTE_W-1:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      decode_byte(b);
      burst_left--;
      sent_bytes++;
   endtask

   task automatic send_word(logic [WORD_W-1:0] w);
      for (int i = 0; i < 4; i++)
         send_byte(w[8*i +: 8]);
   endtask

   // Drop valid and wait for every expected word, then wait on so that a
   // last byte that produces nothing is also through.
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write then read-back; only call while the decoder is idle.
   task automatic write_cell_count(logic [CELL_W-1:0] v);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CELL_COUNT_ADDR;
      pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      cell_count_mirror = v;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[CELL_W-1:0] !== v) begin
         $error("cell_count: expected 0x%0h, got 0x%0h", v, got[CELL_W-1:0]);
         mismatches++;
      end
   endtask

   function automatic logic [WORD_W-1:0] spoiled(logic [WORD_W-1:0] good, bit hit);
      logic [WORD_W-1:0] mask;
      mask = $urandom;
      if (mask == 0)
         mask = 32'h1;
      return hit ? (good ^ mask) : good;
   endfunction

   // Random mix of literals, escaped runs and empty runs filling 'cells'.
   function automatic byte_q_type build_payload(int unsigned cells);
      byte_q_type  q;
      int unsigned left;
      int unsigned n;
      left = cells;
      while (left > 0) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               q = {q, BYTE_W'($urandom_range(0, 254))};
               left--;
            end
            2: begin
               n = $urandom_range(1, (left > 255) ? 255 : left);
               q = {q, ESC_MARK};
               q = {q, BYTE_W'($urandom_range(0, 255))};
               q = {q, BYTE_W'(n)};
               left -= n;
            end
            default: begin
               // empty run, value anything
               q = {q, ESC_MARK};
               q = {q, BYTE_W'($urandom_range(0, 255))};
               q = {q, 8'd0};
            end
         endcase
      end
      return q;
   endfunction

   // Whole frame; 'spoil' names the header or length word to corrupt, if any.
   task automatic send_frame(logic [WORD_W-1:0] time_bits, logic [WORD_W-1:0] cells,
                             byte_q_type payload, int spoil);
      logic [WORD_W-1:0] psize;
      psize = payload.size();
      if (spoil == ERR_NEGATIVE)
         psize[WORD_W-1] = 1'b1;
      send_word(spoiled(TIME_REC_LEN, spoil == ERR_TIME_LEN));
      send_word(time_bits);
      send_word(spoiled(TIME_REC_LEN, spoil == ERR_TIME_END));
      send_word(spoiled(SIZE_REC_LEN, spoil == ERR_SIZE_LEN));
      send_word(spoiled(cells, spoil == ERR_CELLS));
      send_word(psize);
      send_word(spoiled(SIZE_REC_LEN, spoil == ERR_SIZE_END));
      send_word(spoiled(psize, spoil == ERR_PAYLOAD_LEN));
      foreach (payload[i])
         send_byte(payload[i]);
      send_word(spoiled(psize, spoil == ERR_PAYLOAD_END));
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // the maximum plus alternating bit patterns, ending at 1
   task automatic test_register_access();
      write_cell_count(31'h7FFF_FFFF);
      write_cell_count(31'h2AAA_AAAA);
      write_cell_count(31'h5555_5555);
      write_cell_count(31'd1);
   endtask

   // one-cell frames: empty run before a literal zero, then a run of 255s
   task automatic test_single_cell_frames();
      send_frame(32'h0000_0000, 32'd1, {ESC_MARK, 8'h5A, 8'h00, 8'h00}, NO_SPOIL);
      send_frame(32'hFFFF_FFFF, 32'd1, {ESC_MARK, 8'hFF, 8'h01}, NO_SPOIL);
   endtask

   // longest run, empty run of value 255, literals 0 and 254
   task automatic test_long_runs();
      settle();
      write_cell_count(31'd300);
      stall_mode = RX_COIN;
      send_frame(32'h3F80_0000, 32'd300,
                 {ESC_MARK, 8'h00, 8'hFF, 8'h00, 8'hFE, ESC_MARK, 8'hFF, 8'h00,
                  ESC_MARK, 8'hAA, 8'd43}, NO_SPOIL);
   endtask

   // register moves to its maximum in the middle of the payload and back
   // before the trailing length; checks follow the live value
   task automatic test_register_change_mid_frame();
      settle();
      write_cell_count(31'd5);
      stall_mode = RX_EVERY_FOURTH;
      send_word(TIME_REC_LEN);
      send_word(32'h4120_0000);
      send_word(TIME_REC_LEN);
      send_word(SIZE_REC_LEN);
      send_word(32'd5);
      send_word(32'd5);
      send_word(SIZE_REC_LEN);
      send_word(32'd5);
      send_byte(8'h01);
      send_byte(8'h02);
      settle();
      write_cell_count(31'h7FFF_FFFF);
      send_byte(ESC_MARK);
      send_byte(8'h33);
      send_byte(8'd3);
      settle();
      write_cell_count(31'd5);
      send_word(32'd5);
   endtask

   // receiver goes quiet for a long stretch while bytes keep coming, so the
   // result register fills and the byte side has to stall
   task automatic test_receiver_hold();
      settle();
      write_cell_count(31'd40);
      stall_mode  = RX_ALWAYS;
      hold_cycles = 300;
      send_frame($urandom, 32'd40, build_payload(40), NO_SPOIL);
   endtask

   // well-formed frames with random content, sizes and ready patterns
   task automatic test_random_frames();
      int unsigned cells;
      while (sent_bytes < RANDOM_STOP) begin
         cells = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                             : $urandom_range(1, 24);
         if (cells != cell_count_mirror) begin
            settle();
            write_cell_count(CELL_W'(cells));
         end
         stall_mode = rx_mode_type'($urandom_range(0, 3));
         send_frame($urandom, cells, build_payload(cells), NO_SPOIL);
      end
   endtask

   // The error latch only clears on reset, so a single broken frame closes
   // the run; the seed picks which check it trips. Trailing noise must be
   // swallowed without any word.
   task automatic test_final_error();
      err_type     code;
      int unsigned cells;
      byte_q_type  p;
      code  = err_type'($urandom_range(0, 10));
      cells = $urandom_range(1, 12);
      settle();
      write_cell_count(CELL_W'(cells));
      stall_mode = rx_mode_type'($urandom_range(0, 3));
      case (code)
         ERR_MALFORMED: begin
            p = build_payload(cells);
            p = {p, ESC_MARK};
            if ($urandom_range(0, 1) == 1)
               p = {p, BYTE_W'($urandom_range(0, 255))};
         end
         ERR_OVERFLOW: begin
            p = build_payload(cells);
            p = {p, BYTE_W'($urandom_range(0, 254))};
         end
         // one cell short; a one-cell frame ends up with an empty payload
         ERR_COUNT: p = build_payload(cells - 1);
         default:   p = build_payload(cells);
      endcase
      send_frame($urandom, cells, p, code);
      repeat (16) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_single_cell_frames();
      test_long_runs();
      test_register_change_mid_frame();
      test_receiver_hold();
      test_random_frames();
      test_final_error();

      // drain, then give a stray word time to show up
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
